// ===== rtl/pcapdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcapdf_pkg
// Shared types and constants for the pcap stream deframer.
// ----------------------------------------------------------------------------
package pcapdf_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  localparam logic [31:0] MAGIC_NORMAL  = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_SWAPPED = 32'hd4c3b2a1;
  localparam logic [16:0] MAX_CAP_RESET = 17'h10000;

  localparam logic [4:0] POS_MAGIC_END  = 5'd3;
  localparam logic [4:0] POS_SNAP_END   = 5'd19;
  localparam logic [4:0] POS_GLOBAL_END = 5'd23;
  localparam logic [4:0] POS_SECS_END   = 5'd3;
  localparam logic [4:0] POS_USECS_END  = 5'd7;
  localparam logic [4:0] POS_CAP_END    = 5'd11;
  localparam logic [4:0] POS_RECORD_END = 5'd15;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_GLOBAL  = 3'd0,
    KIND_RECORD  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MAGIC     = 2'd1,
    ERR_CAP_LEN   = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic        swapped;
    logic [31:0] link;
    logic [31:0] snap;
    logic [31:0] secs;
    logic [31:0] usecs;
    logic [31:0] orig_len;
    logic [16:0] cap_len;
    logic [7:0]  pbyte;
    logic        last;
    err_t        err;
  } res_t;

  function automatic logic [31:0] byte_reverse(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ===== rtl/pcap_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// pcap_stream_deframer
// Parses a pcap savefile byte stream into header, record and payload results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one stream byte per transfer, or a
//   transfer with stream_end set when the connection closes.
//   Config channel (cfg_valid/cfg_ready): writes max_capture_length; always
//   ready, write only while the block is idle. Reset value is 65536.
//   Output channel (out_valid/out_ready): at most one result per input
//   transfer: global header, record header, payload byte (last marked),
//   clean end or error.
// Throughput: one byte per cycle while the queue has space, set by the
//   single-cycle byte parser. A result is written to the queue by the input
//   transfer that caused it, then loaded into the output register.
// Stall: when the receiver holds out_ready low the output register keeps its
//   result, the queue behind it absorbs up to QUEUE_DEPTH more, and then
//   in_ready drops until space frees up.
// Reset: the parser returns to the global header, the queue and output
//   register empty. After an error or a clean end the parser swallows every
//   further byte without a result until the next reset.
// ----------------------------------------------------------------------------
module pcap_stream_deframer import pcapdf_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input byte stream
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         stream_byte,
  input  logic               stream_end,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        max_capture_length,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         result_kind,
  output logic               byte_order_swapped,
  output logic [31:0]        link_type,
  output logic [31:0]        snap_length,
  output logic signed [31:0] ts_seconds,
  output logic signed [31:0] ts_microseconds,
  output logic [31:0]        original_length,
  output logic [16:0]        capture_length,
  output logic [7:0]         payload_byte,
  output logic               last_payload,
  output logic [1:0]         error_code
);

  logic push, q_full, q_valid, q_pop;
  res_t push_data, q_data, out_data;

  assign cfg_ready = 1'b1;

  // front: byte parser
  pcapdf_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .stream_byte(stream_byte),
    .stream_end (stream_end),
    .cfg_valid  (cfg_valid),
    .cfg_data   (max_capture_length),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  // decoupling queue
  pcapdf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  // back: output register
  pcapdf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign result_kind        = out_data.kind;
  assign byte_order_swapped = out_data.swapped;
  assign link_type          = out_data.link;
  assign snap_length        = out_data.snap;
  assign ts_seconds         = out_data.secs;
  assign ts_microseconds    = out_data.usecs;
  assign original_length    = out_data.orig_len;
  assign capture_length     = out_data.cap_len;
  assign payload_byte       = out_data.pbyte;
  assign last_payload       = out_data.last;
  assign error_code         = out_data.err;

endmodule

// ===== rtl/pcapdf_front.sv =====
// ----------------------------------------------------------------------------
// pcapdf_front
// Byte parser: assembles header words, checks them and emits result records.
// ----------------------------------------------------------------------------
module pcapdf_front import pcapdf_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        stream_end,
  input  logic        cfg_valid,
  input  logic [16:0] cfg_data,
  input  logic        q_full,
  output logic        push,
  output res_t        push_data
);

  localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_BYTES);

  phase_t      phase, phase_next;
  logic [4:0]  cnt, cnt_next;
  logic [31:0] word, word_next;
  logic        swap, swap_next;
  logic [31:0] snap, snap_next;
  logic [31:0] link, link_next;
  logic [31:0] secs, secs_next;
  logic [31:0] usecs, usecs_next;
  logic [16:0] remaining, remaining_next;
  logic        magic_bad, magic_bad_next;
  logic        cap_bad, cap_bad_next;
  logic [16:0] max_cap;

  logic        accept;
  logic [31:0] word_asm;
  logic [31:0] fw;
  logic [16:0] limit;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign limit    = (max_cap < BUF_LIMIT) ? max_cap : BUF_LIMIT;

  always_comb begin
    word_asm = (cnt[1:0] == 2'd0) ? {24'd0, stream_byte}
             : (word | ({24'd0, stream_byte} << {cnt[1:0], 3'b000}));
    fw = swap ? byte_reverse(word_asm) : word_asm;
  end

  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    word_next      = word;
    swap_next      = swap;
    snap_next      = snap;
    link_next      = link;
    secs_next      = secs;
    usecs_next     = usecs;
    remaining_next = remaining;
    magic_bad_next = magic_bad;
    cap_bad_next   = cap_bad;
    push           = 1'b0;
    push_data      = '0;
    if (accept) begin
      unique case (phase) inside
        PH_HALT: begin
        end
        PH_PAYLOAD: begin
          if (stream_end) begin
            push           = 1'b1;
            push_data.kind = KIND_ERROR;
            push_data.err  = ERR_TRUNCATED;
            phase_next     = PH_HALT;
          end else begin
            push            = 1'b1;
            push_data.kind  = KIND_PAYLOAD;
            push_data.pbyte = stream_byte;
            push_data.last  = (remaining <= 17'd1);
            if (remaining <= 17'd1) begin
              remaining_next = '0;
              phase_next     = PH_RECORD;
              cnt_next       = '0;
            end else begin
              remaining_next = remaining - 17'd1;
            end
          end
        end
        PH_GLOBAL, PH_RECORD: begin
          if (stream_end) begin
            push       = 1'b1;
            phase_next = PH_HALT;
            if (cnt == 5'd0) begin
              push_data.kind = KIND_END;
            end else begin
              push_data.kind = KIND_ERROR;
              push_data.err  = ERR_TRUNCATED;
            end
          end else begin
            word_next = word_asm;
            cnt_next  = cnt + 5'd1;
            if (phase == PH_GLOBAL) begin
              if (cnt == POS_MAGIC_END) begin
                swap_next      = (word_asm == MAGIC_SWAPPED);
                magic_bad_next = (word_asm != MAGIC_NORMAL) && (word_asm != MAGIC_SWAPPED);
              end else if (cnt == POS_SNAP_END) begin
                snap_next = fw;
              end else if (cnt == POS_GLOBAL_END) begin
                link_next = fw;
                push      = 1'b1;
                if (magic_bad) begin
                  push_data.kind = KIND_ERROR;
                  push_data.err  = ERR_MAGIC;
                  phase_next     = PH_HALT;
                end else begin
                  push_data.kind    = KIND_GLOBAL;
                  push_data.swapped = swap;
                  push_data.link    = fw;
                  push_data.snap    = snap;
                  phase_next        = PH_RECORD;
                  cnt_next          = '0;
                end
              end
            end else begin
              if (cnt == POS_SECS_END) begin
                secs_next = fw;
              end else if (cnt == POS_USECS_END) begin
                usecs_next = fw;
              end else if (cnt == POS_CAP_END) begin
                // zero or over the smaller of max_cap and the buffer limit is rejected at header end
                if ((fw == 32'd0) || (fw > {15'd0, limit})) begin
                  cap_bad_next   = 1'b1;
                  remaining_next = '0;
                end else begin
                  cap_bad_next   = 1'b0;
                  remaining_next = fw[16:0];
                end
              end else if (cnt == POS_RECORD_END) begin
                push = 1'b1;
                if (cap_bad) begin
                  push_data.kind = KIND_ERROR;
                  push_data.err  = ERR_CAP_LEN;
                  phase_next     = PH_HALT;
                end else begin
                  push_data.kind     = KIND_RECORD;
                  push_data.swapped  = swap;
                  push_data.secs     = secs;
                  push_data.usecs    = usecs;
                  push_data.orig_len = fw;
                  push_data.cap_len  = remaining;
                  phase_next         = PH_PAYLOAD;
                  cnt_next           = '0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_GLOBAL;
      cnt       <= '0;
      word      <= '0;
      swap      <= 1'b0;
      snap      <= '0;
      link      <= '0;
      secs      <= '0;
      usecs     <= '0;
      remaining <= '0;
      magic_bad <= 1'b0;
      cap_bad   <= 1'b0;
      max_cap   <= MAX_CAP_RESET;
    end else begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      word      <= word_next;
      swap      <= swap_next;
      snap      <= snap_next;
      link      <= link_next;
      secs      <= secs_next;
      usecs     <= usecs_next;
      remaining <= remaining_next;
      magic_bad <= magic_bad_next;
      cap_bad   <= cap_bad_next;
      if (cfg_valid) begin
        max_cap <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/pcapdf_queue.sv =====
// ----------------------------------------------------------------------------
// pcapdf_queue
// Short register queue of result records between parser and output stage.
// ----------------------------------------------------------------------------
module pcapdf_queue import pcapdf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output res_t q_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  res_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/pcapdf_back.sv =====
// ----------------------------------------------------------------------------
// pcapdf_back
// Output stage: registers one result record and holds it until transferred.
// ----------------------------------------------------------------------------
module pcapdf_back import pcapdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  res_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic load;

  assign load  = !out_valid || out_ready;
  assign q_pop = q_valid && load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= q_data;
    end
  end

endmodule

// ===== rtl/pcapdf_checker.sv =====
// ----------------------------------------------------------------------------
// pcapdf_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pcapdf_checker import pcapdf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  result_kind,
  input logic [16:0] capture_length,
  input logic [31:0] ts_seconds,
  input logic [1:0]  error_code
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind))
    else $error("result changed while stalled");

  // an accepted error or clean end is not directly followed by another result
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready &&
    (result_kind == KIND_ERROR || result_kind == KIND_END) |=> !out_valid)
    else $error("result after halt");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_ERROR |-> error_code != ERR_NONE)
    else $error("error result without code");

  a_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_RECORD |->
      capture_length != 17'd0 && error_code == ERR_NONE)
    else $error("bad record header result");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |->
      capture_length == 17'd0 && ts_seconds == 32'sd0 && error_code == ERR_NONE)
    else $error("payload result carries header fields");

endmodule

bind pcap_stream_deframer pcapdf_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_kind   (result_kind),
  .capture_length(capture_length),
  .ts_seconds    (ts_seconds),
  .error_code    (error_code)
);
